FILE: src/rhcc_pkg.sv
`timescale 1ns / 1ps

package rhcc_pkg;

  // Field widths of the streams and registers.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FP_W     = 64;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned WLEN_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 88;

  // Register reset values.
  localparam logic [FP_W-1:0]   POLYNOMIAL_RST = 64'd17349423945073011;
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 7'd48;
  localparam logic [LEN_W-1:0]  MIN_CHUNK_RST = 17'd2048;
  localparam logic [LEN_W-1:0]  MAX_CHUNK_RST = 17'd65536;
  localparam logic [FP_W-1:0]   BOUNDARY_MASK_RST = 64'd8191;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL    = 3'd0,
    REG_WINDOW_LENGTH = 3'd1,
    REG_MIN_CHUNK     = 3'd2,
    REG_MAX_CHUNK     = 3'd3,
    REG_BOUNDARY_MASK = 3'd4
  } reg_index_t;

  // Why a chunk was cut after a byte.
  typedef enum logic [1:0] {
    CUT_NONE  = 2'd0,
    CUT_MATCH = 2'd1,
    CUT_LIMIT = 2'd2,
    CUT_END   = 2'd3
  } cut_reason_t;

  // Current register settings.
  typedef struct packed {
    logic [FP_W-1:0]   polynomial;
    logic [WLEN_W-1:0] window_length;
    logic [LEN_W-1:0]  min_chunk_length;
    logic [LEN_W-1:0]  max_chunk_length;
    logic [FP_W-1:0]   boundary_mask;
  } cfg_t;

  // Beat leaving the window ring: entering byte and the byte it displaces.
  typedef struct packed {
    logic [BYTE_W-1:0] new_byte;
    logic [BYTE_W-1:0] old_byte;
    logic              last;
  } win_beat_t;

  // Beat leaving the fingerprint stage.
  typedef struct packed {
    logic [FP_W-1:0] fingerprint;
    logic            last;
  } fp_beat_t;

  // Carry-less product of a byte and the polynomial, kept to 64 bits.
  function automatic logic [FP_W-1:0] byte_term(input logic [BYTE_W-1:0] b,
                                                input logic [FP_W-1:0] poly);
    logic [FP_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ (poly << i);
      end
    end
    return acc;
  endfunction

endpackage

FILE: src/rhcc_window.sv
`timescale 1ns / 1ps

module rhcc_window #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rhcc_pkg::BYTE_W-1:0]       in_byte,
  input  logic                              in_last,
  input  logic [rhcc_pkg::WLEN_W-1:0]       window_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rhcc_pkg::win_beat_t               out_beat
);

  // The window length register is 7 bits, so no more than 127 entries are ever used.
  localparam int unsigned RING_DEPTH = (WINDOW_DEPTH < 128) ? WINDOW_DEPTH : 128;
  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CLAMP = (WINDOW_DEPTH < 127) ? WINDOW_DEPTH : 127;
  localparam logic [rhcc_pkg::WLEN_W-1:0] CLAMP_LEN = rhcc_pkg::WLEN_W'(CLAMP);
  localparam logic [rhcc_pkg::WLEN_W-1:0] ONE_LEN = rhcc_pkg::WLEN_W'(1);

  logic [rhcc_pkg::BYTE_W-1:0] ring_mem [0:RING_DEPTH-1];
  logic [RING_DEPTH-1:0]       entry_vld;
  logic [AW-1:0]               pos;
  logic [rhcc_pkg::WLEN_W-1:0] wlen_eff;
  logic [rhcc_pkg::WLEN_W-1:0] pos_ext;
  logic [rhcc_pkg::WLEN_W-1:0] pos_cur_ext;
  logic [rhcc_pkg::WLEN_W-1:0] pos_inc_ext;
  logic [AW-1:0]               pos_cur;
  logic [AW-1:0]               pos_next;
  logic                        accept;
  logic                        stage_v;
  logic [rhcc_pkg::BYTE_W-1:0] rd_byte;
  logic [rhcc_pkg::BYTE_W-1:0] new_byte;
  logic                        old_vld;
  logic                        last_q;

  // Effective ring length: zero acts as one, large values clamp to the depth (at most 127).
  always_comb begin
    if (window_length == '0) begin
      wlen_eff = ONE_LEN;
    end else if (window_length > CLAMP_LEN) begin
      wlen_eff = CLAMP_LEN;
    end else begin
      wlen_eff = window_length;
    end
  end

  // A position left past a shrunken ring restarts at zero.
  always_comb begin
    pos_ext     = rhcc_pkg::WLEN_W'(pos);
    pos_cur_ext = (pos_ext >= wlen_eff) ? '0 : pos_ext;
    pos_inc_ext = pos_cur_ext + ONE_LEN;
    pos_cur     = AW'(pos_cur_ext);
    pos_next    = (pos_inc_ext >= wlen_eff) ? '0 : AW'(pos_inc_ext);
  end

  assign in_ready = !stage_v || out_ready;
  assign accept   = in_valid && in_ready;

  // Position, entry valid bits and stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v   <= 1'b0;
      pos       <= '0;
      entry_vld <= '0;
    end else begin
      if (accept) begin
        stage_v <= 1'b1;
      end else if (out_ready) begin
        stage_v <= 1'b0;
      end
      if (accept) begin
        if (in_last) begin
          pos       <= '0;
          entry_vld <= '0;
        end else begin
          pos               <= pos_next;
          entry_vld[pos_cur] <= 1'b1;
        end
      end
    end
  end

  // Ring memory: read-first, so the displaced byte comes out as the new one goes in.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[pos_cur] <= in_byte;
      rd_byte           <= ring_mem[pos_cur];
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      new_byte <= in_byte;
      last_q   <= in_last;
      old_vld  <= entry_vld[pos_cur];
    end
  end

  // An entry not written since reset or the end of data reads as zero.
  assign out_valid         = stage_v;
  assign out_beat.new_byte = new_byte;
  assign out_beat.old_byte = old_vld ? rd_byte : '0;
  assign out_beat.last     = last_q;

endmodule

FILE: src/rhcc_fingerprint.sv
`timescale 1ns / 1ps

module rhcc_fingerprint (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rhcc_pkg::FP_W-1:0]     polynomial,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rhcc_pkg::win_beat_t           in_beat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rhcc_pkg::fp_beat_t            out_beat
);

  logic [rhcc_pkg::FP_W-1:0] fp;
  logic [rhcc_pkg::FP_W-1:0] fp_next;
  logic [rhcc_pkg::FP_W-1:0] old_term;
  logic [rhcc_pkg::FP_W-1:0] new_term;
  logic                      stage_v;
  logic                      advance;

  // Remove the oldest byte, shift a byte up, mix in the new byte.
  always_comb begin
    old_term = rhcc_pkg::byte_term(in_beat.old_byte, polynomial);
    new_term = rhcc_pkg::byte_term(in_beat.new_byte, polynomial);
    fp_next  = ((fp - old_term) << 8) ^ new_term;
  end

  assign in_ready = !stage_v || out_ready;
  assign advance  = in_valid && in_ready;

  // Rolling fingerprint and stage occupancy; end of data clears the fingerprint.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
      fp      <= '0;
    end else begin
      if (advance) begin
        stage_v <= 1'b1;
        fp      <= in_beat.last ? '0 : fp_next;
      end else if (out_ready) begin
        stage_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat.fingerprint <= fp_next;
      out_beat.last        <= in_beat.last;
    end
  end

  assign out_valid = stage_v;

endmodule

FILE: src/rhcc_cut.sv
`timescale 1ns / 1ps

module rhcc_cut (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rhcc_pkg::LEN_W-1:0]     min_chunk_length,
  input  logic [rhcc_pkg::LEN_W-1:0]     max_chunk_length,
  input  logic [rhcc_pkg::FP_W-1:0]      boundary_mask,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rhcc_pkg::fp_beat_t             in_beat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           chunk_end,
  output rhcc_pkg::cut_reason_t          cut_reason,
  output logic [rhcc_pkg::LEN_W-1:0]     chunk_length,
  output logic [rhcc_pkg::FP_W-1:0]      fingerprint
);

  logic [rhcc_pkg::LEN_W-1:0] count;
  logic [rhcc_pkg::LEN_W-1:0] len;
  logic [rhcc_pkg::LEN_W-1:0] limit;
  logic                       match;
  logic                       advance;
  rhcc_pkg::cut_reason_t      reason;

  // Chunk length with this byte, and the cut decision in priority order.
  always_comb begin
    len   = count + rhcc_pkg::LEN_W'(1);
    limit = (max_chunk_length > min_chunk_length) ? max_chunk_length : min_chunk_length;
    match = (len > min_chunk_length) && (len <= max_chunk_length) &&
            ((in_beat.fingerprint & boundary_mask) == boundary_mask);
    if (match) begin
      reason = rhcc_pkg::CUT_MATCH;
    end else if (len >= limit) begin
      reason = rhcc_pkg::CUT_LIMIT;
    end else if (in_beat.last) begin
      reason = rhcc_pkg::CUT_END;
    end else begin
      reason = rhcc_pkg::CUT_NONE;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  // Byte count of the open chunk and output beat occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        count     <= (reason != rhcc_pkg::CUT_NONE) ? '0 : len;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      chunk_end    <= (reason != rhcc_pkg::CUT_NONE);
      cut_reason   <= reason;
      chunk_length <= len;
      fingerprint  <= in_beat.fingerprint;
    end
  end

endmodule

FILE: src/rolling_hash_content_chunker.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                           Contents
// s_*       in         s_tvalid s_tready s_tdata s_tlast  data byte, last byte of data set
// m_*       out        m_tvalid m_tready m_tdata m_tuser m_tlast  chunk length, fingerprint,
//                                                       cut reason, chunk end
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// One byte is taken every cycle unless the output stalls; its result passes the window, fingerprint
// and cut registers. The rolling fingerprint update (two carry-less byte terms, a 64-bit subtract,
// shift and xor) is the loop that sets this rate; the ring memory is read and written once per byte.
// Reset is synchronous and clears control, the ring valid bits and the registers; no clearing pass.
// A stalled output backs up the two inner stages, after which s_tready drops.
module rolling_hash_content_chunker #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // [7:0] byte_value
  input  logic                                  s_tlast,   // final_byte
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [rhcc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [16:0] chunk_length, [80:17] fingerprint
  output logic [1:0]                            m_tuser,   // [1:0] cut_reason
  output logic                                  m_tlast,   // chunk_end
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rhcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rhcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  rhcc_pkg::cfg_t                cfg;
  rhcc_pkg::win_beat_t           win_beat;
  rhcc_pkg::fp_beat_t            fp_beat;
  rhcc_pkg::cut_reason_t         cut_reason;
  logic                          win_valid;
  logic                          win_ready;
  logic                          fp_valid;
  logic                          fp_ready;
  logic [rhcc_pkg::LEN_W-1:0]    chunk_length;
  logic [rhcc_pkg::FP_W-1:0]     fingerprint;

  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polynomial       <= rhcc_pkg::POLYNOMIAL_RST;
      cfg.window_length    <= rhcc_pkg::WINDOW_LENGTH_RST;
      cfg.min_chunk_length <= rhcc_pkg::MIN_CHUNK_RST;
      cfg.max_chunk_length <= rhcc_pkg::MAX_CHUNK_RST;
      cfg.boundary_mask    <= rhcc_pkg::BOUNDARY_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rhcc_pkg::REG_POLYNOMIAL:    cfg.polynomial <= cfg_data;
        rhcc_pkg::REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[rhcc_pkg::WLEN_W-1:0];
        rhcc_pkg::REG_MIN_CHUNK:     cfg.min_chunk_length <= cfg_data[rhcc_pkg::LEN_W-1:0];
        rhcc_pkg::REG_MAX_CHUNK:     cfg.max_chunk_length <= cfg_data[rhcc_pkg::LEN_W-1:0];
        rhcc_pkg::REG_BOUNDARY_MASK: cfg.boundary_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window ring.
  rhcc_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .window_length(cfg.window_length),
    .out_valid    (win_valid),
    .out_ready    (win_ready),
    .out_beat     (win_beat)
  );

  // Rolling fingerprint.
  rhcc_fingerprint u_fingerprint (
    .clk       (clk),
    .rst       (rst),
    .polynomial(cfg.polynomial),
    .in_valid  (win_valid),
    .in_ready  (win_ready),
    .in_beat   (win_beat),
    .out_valid (fp_valid),
    .out_ready (fp_ready),
    .out_beat  (fp_beat)
  );

  // Cut decision and output register.
  rhcc_cut u_cut (
    .clk             (clk),
    .rst             (rst),
    .min_chunk_length(cfg.min_chunk_length),
    .max_chunk_length(cfg.max_chunk_length),
    .boundary_mask   (cfg.boundary_mask),
    .in_valid        (fp_valid),
    .in_ready        (fp_ready),
    .in_beat         (fp_beat),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .chunk_end       (m_tlast),
    .cut_reason      (cut_reason),
    .chunk_length    (chunk_length),
    .fingerprint     (fingerprint)
  );

  // Pack the result beat.
  assign m_tdata = {7'b0, fingerprint, chunk_length};
  assign m_tuser = cut_reason;

endmodule
